@@ design/hfvbs_pkg.sv @@
// shared types, constants and the half-float decode for the volume band statistics block
package hfvbs_pkg;

  // fixed point format and limits
  localparam int FRAC_BITS   = 16;
  localparam int MAX_TEXELS  = 1048576;
  localparam int MAX_SLICES  = 256;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef logic signed [23:0] fix_t;

  localparam fix_t       T_POS_MAX  = 24'sh7FFFFF;
  localparam fix_t       T_NEG_MAX  = 24'sh800000;
  localparam fix_t       ONE_FIXED  = 24'sh010000;
  localparam logic [23:0] S_MAX     = 24'hFFFFFF;

  // register indexes on the config port
  localparam logic REG_DEPTH  = 1'b0;
  localparam logic REG_THRESH = 1'b1;

  // band codes
  localparam logic [1:0] BAND_NEAR = 2'd0;
  localparam logic [1:0] BAND_MID  = 2'd1;
  localparam logic [1:0] BAND_FAR  = 2'd2;

  // summary kinds
  localparam logic [1:0] KIND_WHOLE = 2'd0;
  localparam logic [1:0] KIND_LAST  = 2'd3;

  // one classified item handed from front to back
  typedef struct packed {
    logic       action;
    fix_t       red;
    fix_t       green;
    fix_t       blue;
    fix_t       transmit;
    logic [7:0] slice;
    logic [1:0] band;
  } item_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_SQUARE,
    B_ROOT,
    B_ACCUM,
    B_DIV_T_GO,
    B_DIV_T_WAIT,
    B_DIV_S_GO,
    B_DIV_S_WAIT,
    B_EMIT,
    B_CLEAR
  } back_state_t;

  // half-float to signed Q8.16, subnormals flushed, out of range saturated
  function automatic fix_t half_to_fixed(input logic [15:0] h);
    logic [4:0]  e;
    logic [10:0] m;
    logic [39:0] mag;
    logic [39:0] neg;
    fix_t        res;
    e = h[14:10];
    m = {1'b1, h[9:0]};
    if (e >= 5'd9) begin
      mag = {29'd0, m} << (e - 5'd9);
    end else begin
      mag = {29'd0, m} >> (5'd9 - e);
    end
    if (e == 5'd31) begin
      mag = 40'd8388608;
    end
    if (h[15]) begin
      if (mag > 40'd8388608) begin
        mag = 40'd8388608;
      end
      neg = 40'd0 - mag;
      res = neg[23:0];
    end else begin
      if (mag > 40'd8388607) begin
        mag = 40'd8388607;
      end
      res = mag[23:0];
    end
    if (e == 5'd0) begin
      res = '0;
    end
    return res;
  endfunction

endpackage

@@ design/hfvbs_in_if.sv @@
// texel input channel
interface hfvbs_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [15:0] red_half;
  logic [15:0] green_half;
  logic [15:0] blue_half;
  logic [15:0] alpha_half;
  logic [7:0]  slice_index;

  modport source (output valid, action, red_half, green_half, blue_half, alpha_half,
                  slice_index, input ready);
  modport sink (input valid, action, red_half, green_half, blue_half, alpha_half,
                slice_index, output ready);
endinterface

@@ design/hfvbs_out_if.sv @@
// summary output channel
interface hfvbs_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         summary_kind;
  logic [20:0]        texel_total;
  logic signed [23:0] min_transmit;
  logic signed [23:0] max_transmit;
  logic signed [23:0] mean_transmit;
  logic [23:0]        min_scatter;
  logic [23:0]        max_scatter;
  logic [23:0]        mean_scatter;
  logic [7:0]         first_slice;
  logic [8:0]         end_slice;
  logic               likely_visible;
  logic               last_result;

  modport source (output valid, summary_kind, texel_total, min_transmit, max_transmit,
                  mean_transmit, min_scatter, max_scatter, mean_scatter, first_slice,
                  end_slice, likely_visible, last_result, input ready);
  modport sink (input valid, summary_kind, texel_total, min_transmit, max_transmit,
                mean_transmit, min_scatter, max_scatter, mean_scatter, first_slice,
                end_slice, likely_visible, last_result, output ready);
endinterface

@@ design/hfvbs_front.sv @@
// front: accepts texels, decodes the half-floats and picks the depth band
module hfvbs_front import hfvbs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  hfvbs_in_if.sink   texel,
  input  logic [8:0] volume_depth,
  input  logic       queue_full,
  output logic       push,
  output item_t      push_item
);

  logic       stage_valid;
  item_t      stage_item;
  item_t      decoded;
  logic [8:0] depth_eff;
  logic [9:0] slice3;
  logic [9:0] depth1;
  logic [9:0] depth2;

  // depth clamped to the supported range
  always_comb begin
    if (volume_depth == 9'd0) begin
      depth_eff = 9'd1;
    end else if (volume_depth > 9'(MAX_SLICES)) begin
      depth_eff = 9'(MAX_SLICES);
    end else begin
      depth_eff = volume_depth;
    end
  end

  // band = min(2, slice*3/depth) by two compares
  assign slice3 = 10'(texel.slice_index) * 10'd3;
  assign depth1 = {1'b0, depth_eff};
  assign depth2 = {depth_eff, 1'b0};

  always_comb begin
    decoded.action   = texel.action;
    decoded.red      = half_to_fixed(texel.red_half);
    decoded.green    = half_to_fixed(texel.green_half);
    decoded.blue     = half_to_fixed(texel.blue_half);
    decoded.transmit = half_to_fixed(texel.alpha_half);
    decoded.slice    = texel.slice_index;
    if (slice3 < depth1) begin
      decoded.band = BAND_NEAR;
    end else if (slice3 < depth2) begin
      decoded.band = BAND_MID;
    end else begin
      decoded.band = BAND_FAR;
    end
  end

  assign texel.ready = !stage_valid || !queue_full;
  assign push        = stage_valid && !queue_full;
  assign push_item   = stage_item;

  // one decode stage ahead of the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (texel.valid && texel.ready) begin
      stage_valid <= 1'b1;
    end else if (push) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (texel.valid && texel.ready) begin
      stage_item <= decoded;
    end
  end

endmodule

@@ design/hfvbs_queue.sv @@
// short queue between front and back
module hfvbs_queue import hfvbs_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  q_valid,
  output item_t q_item
);

  item_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;

  assign full    = fill == (QPTR_W + 1)'(QUEUE_DEPTH);
  assign q_valid = fill != '0;
  assign q_item  = entries[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

@@ design/hfvbs_div.sv @@
// restoring divider, one quotient bit per cycle
module hfvbs_div import hfvbs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [44:0] dividend,
  input  logic [20:0] divisor,
  output logic        busy,
  output logic [44:0] quotient
);

  logic [21:0] rem;
  logic [21:0] rem_sh;
  logic [5:0]  steps;

  assign rem_sh = {rem[20:0], quotient[44]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && steps == 6'd0) begin
      busy <= 1'b0;
    end
  end

  // shift in one dividend bit, subtract when it fits
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
      steps    <= 6'd44;
    end else if (busy) begin
      steps <= steps - 1'b1;
      if (rem_sh >= {1'b0, divisor}) begin
        rem      <= rem_sh - {1'b0, divisor};
        quotient <= {quotient[43:0], 1'b1};
      end else begin
        rem      <= rem_sh;
        quotient <= {quotient[43:0], 1'b0};
      end
    end
  end

endmodule

@@ design/hfvbs_back.sv @@
// back: magnitude, accumulation, and the summary sequence on finish
module hfvbs_back import hfvbs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        pop,
  input  logic [8:0]  volume_depth,
  input  logic [15:0] visible_threshold,
  hfvbs_out_if.source summary
);

  back_state_t state, state_next;
  item_t       item;
  logic [4:0]  cnt;
  logic [47:0] prod;
  logic [47:0] sumsq;
  logic [25:0] rem;
  logic [23:0] root;
  logic [27:0] rem_sh;
  logic [27:0] trial;
  logic [1:0]  kind;
  fix_t        mean_t_q;
  logic [23:0] mean_s_q;
  fix_t        mult_op;
  logic signed [47:0] mult_res;

  // stores, index 0 whole volume, 1..3 bands
  logic [20:0]        acc_count [4];
  fix_t               acc_min_t [4];
  fix_t               acc_max_t [4];
  logic signed [44:0] acc_sum_t [4];
  logic [23:0]        acc_min_s [4];
  logic [23:0]        acc_max_s [4];
  logic [43:0]        acc_sum_s [4];
  logic [7:0]         band_begin [3];
  logic [8:0]         band_end [3];
  logic               band_valid [3];

  logic        div_start;
  logic [44:0] div_dividend;
  logic        div_busy;
  logic [44:0] div_quotient;
  logic [44:0] sum_t_mag;
  logic        emit_load;
  logic        out_free;

  hfvbs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (acc_count[kind]),
    .busy     (div_busy),
    .quotient (div_quotient)
  );

  assign out_free = !summary.valid || summary.ready;
  assign sum_t_mag = acc_sum_t[kind][44] ? 45'(-acc_sum_t[kind]) : acc_sum_t[kind];

  // channel picked for the shared multiplier
  always_comb begin
    case (cnt[1:0])
      2'd0:    mult_op = item.red;
      2'd1:    mult_op = item.green;
      default: mult_op = item.blue;
    endcase
  end
  assign mult_res = mult_op * mult_op;

  // square root step
  assign rem_sh = {rem, sumsq[47:46]};
  assign trial  = {2'b00, root, 2'b01};

  // next state and control
  always_comb begin
    state_next   = state;
    pop          = 1'b0;
    div_start    = 1'b0;
    div_dividend = {1'b0, acc_sum_s[kind]};
    emit_load    = 1'b0;
    case (state)
      B_IDLE: begin
        if (q_valid) begin
          pop        = 1'b1;
          state_next = q_item.action ? B_DIV_T_GO : B_SQUARE;
        end
      end
      B_SQUARE: begin
        if (cnt == 5'd3) begin
          state_next = B_ROOT;
        end
      end
      B_ROOT: begin
        if (cnt == 5'd23) begin
          state_next = B_ACCUM;
        end
      end
      B_ACCUM: begin
        state_next = B_IDLE;
      end
      B_DIV_T_GO: begin
        div_start    = 1'b1;
        div_dividend = sum_t_mag;
        state_next   = B_DIV_T_WAIT;
      end
      B_DIV_T_WAIT: begin
        if (!div_busy) begin
          state_next = B_DIV_S_GO;
        end
      end
      B_DIV_S_GO: begin
        div_start  = 1'b1;
        state_next = B_DIV_S_WAIT;
      end
      B_DIV_S_WAIT: begin
        if (!div_busy) begin
          state_next = B_EMIT;
        end
      end
      B_EMIT: begin
        if (out_free) begin
          emit_load  = 1'b1;
          state_next = (kind == KIND_LAST) ? B_CLEAR : B_DIV_T_GO;
        end
      end
      B_CLEAR: begin
        state_next = B_IDLE;
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // item working registers
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        item <= q_item;
        cnt  <= '0;
        kind <= KIND_WHOLE;
      end
      B_SQUARE: begin
        prod <= 48'(mult_res);
        if (cnt == 5'd0) begin
          sumsq <= '0;
        end else begin
          sumsq <= sumsq + prod;
        end
        if (cnt == 5'd3) begin
          cnt  <= '0;
          rem  <= '0;
          root <= '0;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
      B_ROOT: begin
        cnt   <= cnt + 1'b1;
        sumsq <= {sumsq[45:0], 2'b00};
        if (rem_sh >= trial) begin
          rem  <= 26'(rem_sh - trial);
          root <= {root[22:0], 1'b1};
        end else begin
          rem  <= rem_sh[25:0];
          root <= {root[22:0], 1'b0};
        end
      end
      B_DIV_T_WAIT: begin
        if (!div_busy) begin
          mean_t_q <= acc_sum_t[kind][44] ? fix_t'(-div_quotient[23:0]) : div_quotient[23:0];
        end
      end
      B_DIV_S_WAIT: begin
        if (!div_busy) begin
          mean_s_q <= div_quotient[23:0];
        end
      end
      B_EMIT: begin
        if (out_free) begin
          kind <= kind + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // stores: texel goes to the whole volume and to its band
  always_ff @(posedge clk) begin
    if (rst || state == B_CLEAR) begin
      for (int k = 0; k < 4; k++) begin
        acc_count[k] <= '0;
        acc_min_t[k] <= T_POS_MAX;
        acc_max_t[k] <= T_NEG_MAX;
        acc_sum_t[k] <= '0;
        acc_min_s[k] <= S_MAX;
        acc_max_s[k] <= '0;
        acc_sum_s[k] <= '0;
      end
      for (int b = 0; b < 3; b++) begin
        band_begin[b] <= '0;
        band_end[b]   <= '0;
        band_valid[b] <= 1'b0;
      end
    end else if (state == B_ACCUM && acc_count[0] < 21'(MAX_TEXELS)) begin
      for (int k = 0; k < 4; k++) begin
        if (k == 0 || 3'(k) == {1'b0, item.band} + 3'd1) begin
          acc_count[k] <= acc_count[k] + 1'b1;
          if (item.transmit < acc_min_t[k]) begin
            acc_min_t[k] <= item.transmit;
          end
          if (item.transmit > acc_max_t[k]) begin
            acc_max_t[k] <= item.transmit;
          end
          acc_sum_t[k] <= acc_sum_t[k] + 45'(item.transmit);
          if (root < acc_min_s[k]) begin
            acc_min_s[k] <= root;
          end
          if (root > acc_max_s[k]) begin
            acc_max_s[k] <= root;
          end
          acc_sum_s[k] <= acc_sum_s[k] + 44'(root);
        end
      end
      for (int b = 0; b < 3; b++) begin
        if (2'(b) == item.band) begin
          if (!band_valid[b]) begin
            band_valid[b] <= 1'b1;
            band_begin[b] <= item.slice;
          end
          band_end[b] <= 9'(item.slice) + 9'd1;
        end
      end
    end
  end

  // summary fields for the current kind
  logic [8:0]         depth_eff;
  logic signed [26:0] budget;
  logic [7:0]         sel_first;
  logic [8:0]         sel_end;

  always_comb begin
    if (volume_depth == 9'd0) begin
      depth_eff = 9'd1;
    end else if (volume_depth > 9'(MAX_SLICES)) begin
      depth_eff = 9'(MAX_SLICES);
    end else begin
      depth_eff = volume_depth;
    end
    budget = 27'sd65536 - 27'(acc_min_t[0]) + $signed({3'b000, acc_max_s[0]});
    case (kind)
      2'd1: begin
        sel_first = band_valid[0] ? band_begin[0] : 8'd0;
        sel_end   = band_valid[0] ? band_end[0] : 9'd0;
      end
      2'd2: begin
        sel_first = band_valid[1] ? band_begin[1] : 8'd0;
        sel_end   = band_valid[1] ? band_end[1] : 9'd0;
      end
      2'd3: begin
        sel_first = band_valid[2] ? band_begin[2] : 8'd0;
        sel_end   = band_valid[2] ? band_end[2] : 9'd0;
      end
      default: begin
        sel_first = 8'd0;
        sel_end   = depth_eff;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      summary.valid <= 1'b0;
    end else if (emit_load) begin
      summary.valid <= 1'b1;
    end else if (summary.ready) begin
      summary.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      summary.summary_kind   <= kind;
      summary.texel_total    <= acc_count[kind];
      summary.min_transmit   <= acc_min_t[kind];
      summary.max_transmit   <= acc_max_t[kind];
      summary.mean_transmit  <= (acc_count[kind] == '0) ? ONE_FIXED : mean_t_q;
      summary.min_scatter    <= acc_min_s[kind];
      summary.max_scatter    <= acc_max_s[kind];
      summary.mean_scatter   <= (acc_count[kind] == '0) ? 24'd0 : mean_s_q;
      summary.first_slice    <= sel_first;
      summary.end_slice      <= sel_end;
      summary.likely_visible <= (kind == KIND_WHOLE) &&
                                (budget >= $signed({11'd0, visible_threshold}));
      summary.last_result    <= kind == KIND_LAST;
    end
  end

endmodule

@@ design/half_float_volume_band_statistics_top.sv @@
// top level: config registers, front, queue and back
//
//  channel   | dir | handshake          | payload
//  texel     | in  | valid/ready        | action, rgba halves, slice_index
//  summary   | out | valid/ready        | one summary per transfer, four per finish
//  apb       | in  | psel/penable/pready| volume_depth at 0, visible_threshold at 4
//
// a texel passes through the back as a pop, the squares on the one
// shared multiplier, the bit-serial square root and the accumulation.
// a finish runs two divisions per summary in the shared one-bit-per-cycle
// divider, then clears the stores.
// reset is synchronous; the front and a four-entry queue keep taking texels
// while the back works, and a stalled summary holds the back in place.
module half_float_volume_band_statistics_top import hfvbs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  hfvbs_in_if.sink    texel,
  hfvbs_out_if.source summary,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [8:0]  volume_depth;
  logic [15:0] visible_threshold;
  logic        queue_full;
  logic        push;
  item_t       push_item;
  logic        pop;
  logic        q_valid;
  item_t       q_item;

  assign pready = 1'b1;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      volume_depth      <= 9'd32;
      visible_threshold <= 16'd1285;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_DEPTH:  volume_depth      <= pwdata[8:0];
        REG_THRESH: visible_threshold <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[2])
      REG_DEPTH:  prdata = {23'd0, volume_depth};
      REG_THRESH: prdata = {16'd0, visible_threshold};
      default:    prdata = '0;
    endcase
  end

  hfvbs_front u_front (
    .clk          (clk),
    .rst          (rst),
    .texel        (texel),
    .volume_depth (volume_depth),
    .queue_full   (queue_full),
    .push         (push),
    .push_item    (push_item)
  );

  hfvbs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  hfvbs_back u_back (
    .clk               (clk),
    .rst               (rst),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .pop               (pop),
    .volume_depth      (volume_depth),
    .visible_threshold (visible_threshold),
    .summary           (summary)
  );

endmodule

@@ design/hfvbs_checker.sv @@
// port-level checks on the summary channel, bound to the top level
module hfvbs_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         kind,
  input logic [20:0]        total,
  input logic signed [23:0] mean_t,
  input logic [23:0]        mean_s,
  input logic [7:0]         first,
  input logic               visible,
  input logic               last
);

  // a stalled summary stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(total))
    else $error("summary changed while stalled");

  // last flag only on the far band
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (kind == 2'd3)))
    else $error("last flag on wrong summary");

  // visibility and first slice only meaningful as given per kind
  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != 2'd0 |-> !visible)
    else $error("visible flag on a band summary");

  a_whole: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == 2'd0 |-> first == 8'd0)
    else $error("whole volume first slice not zero");

  // empty set means
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && total == 21'd0 |-> mean_s == 24'd0 && mean_t == 24'sh010000)
    else $error("empty summary means wrong");

endmodule

bind half_float_volume_band_statistics_top hfvbs_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (summary.valid),
  .out_ready (summary.ready),
  .kind      (summary.summary_kind),
  .total     (summary.texel_total),
  .mean_t    (summary.mean_transmit),
  .mean_s    (summary.mean_scatter),
  .first     (summary.first_slice),
  .visible   (summary.likely_visible),
  .last      (summary.last_result)
);

@@ bench/half_float_volume_band_statistics_top_tb.sv @@
// testbench for the volume band statistics block: random texel streams checked against a predictor
module half_float_volume_band_statistics_top_tb import hfvbs_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam bit ACT_TEXEL  = 1'b0;
  localparam bit ACT_FINISH = 1'b1;
  localparam int DRAIN_WAIT = 600;

  typedef struct {
    bit         action;
    bit         drain;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] alpha;
    logic [7:0]  slice;
  } texel_item_t;

  typedef struct {
    logic [1:0]  kind;
    logic [20:0] total;
    logic [23:0] min_t;
    logic [23:0] max_t;
    logic [23:0] mean_t;
    logic [23:0] min_s;
    logic [23:0] max_s;
    logic [23:0] mean_s;
    logic [7:0]  first;
    logic [8:0]  last_end;
    logic        visible;
    logic        last;
  } summary_rec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  hfvbs_in_if  texel_ch ();
  hfvbs_out_if summary_ch ();

  half_float_volume_band_statistics_top uut (
    .clk(clk), .rst(rst), .texel(texel_ch), .summary(summary_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  texel_item_t  texel_queue[$];
  summary_rec_t summaries_due[$];
  int  errors = 0;
  int  results_seen = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  int  hold_left = 0;
  bit  hold_done = 0;
  bit  send_burst = 0;
  bit  recv_burst = 0;

  // predictor copy of the registers and stores
  logic [8:0]  depth_reg = 9'd32;
  logic [15:0] thresh_reg = 16'd1285;
  longint cnt[4], mn_t[4], mx_t[4], sum_t[4], mn_s[4], mx_s[4], sum_s[4];
  longint band_lo[3], band_hi[3];
  bit     band_seen[3];

  function automatic longint decode_half(logic [15:0] h);
    int     ex;
    longint mag;
    ex = h[14:10];
    if (ex == 0) return 0;
    if (ex == 31) mag = 64'd8388608;
    else if (ex >= 9) mag = longint'({1'b1, h[9:0]}) << (ex - 9);
    else mag = longint'({1'b1, h[9:0]}) >> (9 - ex);
    if (h[15]) return (mag > 8388608) ? -8388608 : -mag;
    return (mag > 8388607) ? 8388607 : mag;
  endfunction

  function automatic longint int_root(longint v);
    longint r;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      if ((r + (64'd1 << b)) * (r + (64'd1 << b)) <= v) r = r + (64'd1 << b);
    end
    return r;
  endfunction

  function automatic longint depth_used();
    if (depth_reg == 0) return 1;
    if (depth_reg > 256) return 256;
    return depth_reg;
  endfunction

  task automatic wipe_stores();
    for (int k = 0; k < 4; k++) begin
      cnt[k] = 0; mn_t[k] = 8388607; mx_t[k] = -8388608; sum_t[k] = 0;
      mn_s[k] = 64'hFFFFFF; mx_s[k] = 0; sum_s[k] = 0;
    end
    for (int k = 0; k < 3; k++) begin
      band_lo[k] = 0; band_hi[k] = 0; band_seen[k] = 0;
    end
  endtask

  task automatic fold_into(int k, longint t, longint s);
    cnt[k]++;
    if (t < mn_t[k]) mn_t[k] = t;
    if (t > mx_t[k]) mx_t[k] = t;
    sum_t[k] += t;
    if (s < mn_s[k]) mn_s[k] = s;
    if (s > mx_s[k]) mx_s[k] = s;
    sum_s[k] += s;
  endtask

  // work out what one accepted transfer does to the stores
  task automatic absorb_texel(texel_item_t it);
    longint r, g, b, t, s, band;
    summary_rec_t rec;
    if (it.action == ACT_FINISH) begin
      for (int k = 0; k < 4; k++) begin
        rec.kind   = 2'(k);
        rec.total  = 21'(cnt[k]);
        rec.min_t  = 24'(mn_t[k]);
        rec.max_t  = 24'(mx_t[k]);
        rec.mean_t = (cnt[k] > 0) ? 24'(sum_t[k] / cnt[k]) : 24'h010000;
        rec.min_s  = 24'(mn_s[k]);
        rec.max_s  = 24'(mx_s[k]);
        rec.mean_s = (cnt[k] > 0) ? 24'(sum_s[k] / cnt[k]) : 24'd0;
        if (k == 0) begin
          rec.first    = 0;
          rec.last_end = 9'(depth_used());
          rec.visible  = ((65536 - mn_t[0]) + mx_s[0]) >= longint'(thresh_reg);
        end else begin
          rec.first    = band_seen[k-1] ? 8'(band_lo[k-1]) : 8'd0;
          rec.last_end = band_seen[k-1] ? 9'(band_hi[k-1]) : 9'd0;
          rec.visible  = 0;
        end
        rec.last = (k == 3);
        summaries_due.push_back(rec);
      end
      wipe_stores();
    end else if (cnt[0] < MAX_TEXELS) begin
      r = decode_half(it.red);
      g = decode_half(it.green);
      b = decode_half(it.blue);
      t = decode_half(it.alpha);
      s = int_root(r * r + g * g + b * b);
      if (s > 64'hFFFFFF) s = 64'hFFFFFF;
      band = (longint'(it.slice) * 3) / depth_used();
      if (band > 2) band = 2;
      fold_into(0, t, s);
      fold_into(int'(band) + 1, t, s);
      if (!band_seen[band]) begin
        band_seen[band] = 1;
        band_lo[band] = it.slice;
      end
      band_hi[band] = longint'(it.slice) + 1;
    end
  endtask

  function automatic int draw_gap(bit burst);
    return burst ? 0 : $urandom_range(0, 12);
  endfunction

  // texel driver
  always @(posedge clk) begin
    texel_item_t cur, nxt;
    if (rst) begin
      texel_ch.valid <= 1'b0;
    end else begin
      if (texel_ch.valid && texel_ch.ready) begin
        cur.action = texel_ch.action;
        cur.red    = texel_ch.red_half;
        cur.green  = texel_ch.green_half;
        cur.blue   = texel_ch.blue_half;
        cur.alpha  = texel_ch.alpha_half;
        cur.slice  = texel_ch.slice_index;
        absorb_texel(cur);
      end
      if (!texel_ch.valid || texel_ch.ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          texel_ch.valid <= 1'b0;
        end else if (texel_queue.size() > 0 && texel_queue[0].drain) begin
          // sender pause until every summary is back
          if (summaries_due.size() == 0) void'(texel_queue.pop_front());
          texel_ch.valid <= 1'b0;
        end else if (texel_queue.size() > 0) begin
          nxt = texel_queue.pop_front();
          texel_ch.action      <= nxt.action;
          texel_ch.red_half    <= nxt.red;
          texel_ch.green_half  <= nxt.green;
          texel_ch.blue_half   <= nxt.blue;
          texel_ch.alpha_half  <= nxt.alpha;
          texel_ch.slice_index <= nxt.slice;
          texel_ch.valid       <= 1'b1;
          if ($urandom_range(0, 29) == 0) send_burst <= !send_burst;
          gap_left <= draw_gap(send_burst);
        end else begin
          texel_ch.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      errors++;
      $display("%0t: mismatch on %s, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // summary monitor and receiver stalls
  always @(posedge clk) begin
    summary_rec_t want;
    if (rst) begin
      summary_ch.ready <= 1'b0;
    end else begin
      if (summary_ch.valid && summary_ch.ready) begin
        results_seen <= results_seen + 1;
        if (summaries_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected summary transfer, kind %0d", $time, summary_ch.summary_kind);
        end else begin
          want = summaries_due.pop_front();
          check_field("summary_kind", want.kind, summary_ch.summary_kind);
          check_field("texel_total", want.total, summary_ch.texel_total);
          check_field("min_transmit", want.min_t, summary_ch.min_transmit[23:0]);
          check_field("max_transmit", want.max_t, summary_ch.max_transmit[23:0]);
          check_field("mean_transmit", want.mean_t, summary_ch.mean_transmit[23:0]);
          check_field("min_scatter", want.min_s, summary_ch.min_scatter);
          check_field("max_scatter", want.max_s, summary_ch.max_scatter);
          check_field("mean_scatter", want.mean_s, summary_ch.mean_scatter);
          check_field("first_slice", want.first, summary_ch.first_slice);
          check_field("end_slice", want.last_end, summary_ch.end_slice);
          check_field("likely_visible", want.visible, summary_ch.likely_visible);
          check_field("last_result", want.last, summary_ch.last_result);
        end
        if ($urandom_range(0, 15) == 0) recv_burst <= !recv_burst;
        stall_left <= draw_gap(recv_burst);
        summary_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        summary_ch.ready <= 1'b0;
      end else begin
        summary_ch.ready <= (hold_left == 0);
      end
    end
  end

  // one long receiver hold-off while texels keep coming
  always @(posedge clk) begin
    if (!rst && !hold_done && results_seen >= 40) begin
      hold_done <= 1'b1;
      hold_left <= 500;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  task automatic reg_write(logic idx, logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(idx) << 2;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_DEPTH) depth_reg = val[8:0];
    else thresh_reg = val[15:0];
  endtask

  task automatic add_texel(bit act, logic [15:0] r, logic [15:0] g, logic [15:0] b,
                           logic [15:0] a, logic [7:0] sl);
    texel_item_t it;
    it.action = act; it.drain = 0;
    it.red = r; it.green = g; it.blue = b; it.alpha = a; it.slice = sl;
    texel_queue.push_back(it);
  endtask

  // half pattern: mostly ordinary magnitudes, some raw bit patterns
  function automatic logic [15:0] pick_half();
    if ($urandom_range(0, 4) == 0) return 16'($urandom);
    return {1'($urandom), 5'($urandom_range(6, 18)), 10'($urandom)};
  endfunction

  task automatic add_random(int n);
    logic [7:0] sl;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        add_texel(ACT_FINISH, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  8'($urandom));
      end else begin
        if ($urandom_range(0, 9) == 0) sl = 8'($urandom);
        else sl = 8'($urandom_range(0, int'(depth_used()) - 1));
        add_texel(ACT_TEXEL, pick_half(), pick_half(), pick_half(), pick_half(), sl);
      end
    end
    add_texel(ACT_FINISH, '0, '0, '0, '0, '0);
  endtask

  task automatic wait_idle();
    while (texel_queue.size() > 0 || texel_ch.valid || summaries_due.size() > 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // run limit
  initial begin
    #8_000_000;
    $display("** half_float_volume_band_statistics_top: FAILED **");
    $finish;
  end

  // stimulus and final verdict
  initial begin
    texel_item_t pause;
    texel_ch.valid = 1'b0; texel_ch.action = 1'b0;
    texel_ch.red_half = '0; texel_ch.green_half = '0; texel_ch.blue_half = '0;
    texel_ch.alpha_half = '0; texel_ch.slice_index = '0;
    summary_ch.ready = 1'b0;
    wipe_stores();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty finish, special halves, band edges
    add_texel(ACT_FINISH, '0, '0, '0, '0, '0);
    add_texel(ACT_TEXEL, 16'h0000, 16'h0001, 16'h83FF, 16'h3C00, 8'd0);
    add_texel(ACT_TEXEL, 16'h7C00, 16'h0000, 16'h0000, 16'hFC00, 8'd10);
    add_texel(ACT_TEXEL, 16'h7E00, 16'hFE00, 16'h7BFF, 16'h7BFF, 8'd11);
    add_texel(ACT_TEXEL, 16'hFBFF, 16'h0400, 16'h1400, 16'hFBFF, 8'd21);
    add_texel(ACT_TEXEL, 16'h2401, 16'hA401, 16'h5BFF, 16'h0000, 8'd31);
    add_texel(ACT_TEXEL, 16'h3800, 16'h3800, 16'h3800, 16'hB800, 8'd255);
    add_texel(ACT_TEXEL, 16'hFFFF, 16'h7FFF, 16'h5800, 16'h5BFF, 8'd5);
    add_texel(ACT_FINISH, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
    add_texel(ACT_TEXEL, 16'h3C00, 16'h0000, 16'h0000, 16'h3C00, 8'd16);
    add_texel(ACT_FINISH, '0, '0, '0, '0, '0);
    pause.action = ACT_TEXEL; pause.drain = 1;
    texel_queue.push_back(pause);
    add_random(50);
    wait_idle();

    // register settings, extremes among them
    reg_write(REG_DEPTH, 32'd1);
    reg_write(REG_THRESH, 32'd0);
    add_random(40);
    wait_idle();
    reg_write(REG_DEPTH, 32'd256);
    reg_write(REG_THRESH, 32'd65535);
    add_random(50);
    wait_idle();
    reg_write(REG_DEPTH, 32'd0);
    reg_write(REG_THRESH, 32'd1285);
    add_random(20);
    wait_idle();
    reg_write(REG_DEPTH, 32'd511);
    reg_write(REG_THRESH, 32'($urandom_range(0, 65535)));
    add_random(30);
    wait_idle();
    reg_write(REG_DEPTH, 32'($urandom_range(3, 200)));
    reg_write(REG_THRESH, 32'($urandom_range(0, 65535)));
    add_random(60);
    wait_idle();

    if (errors == 0) begin
      $display("** half_float_volume_band_statistics_top: PASSED **");
    end else begin
      $display("** half_float_volume_band_statistics_top: FAILED **");
    end
    $finish;
  end

endmodule
